[hdl/xxrr_pkg.sv]
// Package for the xon/xoff round-robin host arbiter.
// Holds event and status codes, list control struct and field widths.
// No dependencies.
package xxrr_pkg;

  localparam int HOST_W   = 3;  // width of a host id
  localparam int HOST_IDS = 8;  // host ids reachable by a 3-bit id / 8-bit mask
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SELECT   = 3'd0,
    ACT_ACTIVE   = 3'd1,
    ACT_INACTIVE = 3'd2,
    ACT_XOFF     = 3'd3,
    ACT_XON      = 3'd4
  } act_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  // operation applied to the eligible list this cycle
  typedef enum logic [1:0] {
    LOP_NONE   = 2'd0,
    LOP_SELECT = 2'd1,
    LOP_REMOVE = 2'd2,
    LOP_APPEND = 2'd3
  } lop_t;

  typedef struct packed {
    lop_t              op;
    logic [HOST_W-1:0] host;
  } list_ctl_t;

endpackage

[hdl/xon_xoff_round_robin_host_arbiter.sv]
// Round-robin host arbiter with xon/xoff flow control, top level.
// Depends on xxrr_pkg and xxrr_cell.
//
// Usage:
//  - Input stream (in_*): one event per beat, action and host id in in_tdata.
//    Select grants the host at the head of the eligible list and moves it to
//    the tail; the other events set or clear a host's active or xoff flag.
//  - Output stream (out_*): exactly one result beat per event, in order.
//  - cfg_wr_en/cfg_wr_data write the host presence mask. Dropping a host
//    clears its flags at once and takes it out of the list.
// Timing:
//  - Result is registered: it appears the cycle after the event is taken.
//  - One event per cycle sustained unless compaction or out_tready stalls it;
//    the list is a row of NUM_HOSTS slot cells updated together (shift, rotate
//    or append). After a mask write that drops eligible hosts, in_tready is
//    held low while the list is compacted one host a cycle.
//  - If out_tready is low, the result is held and in_tready falls until the
//    beat is taken.
// Reset: all hosts absent, inactive, not xoffed, list empty. List slots are
//  not cleared; no clearing pass is needed.
module xon_xoff_round_robin_host_arbiter import xxrr_pkg::*; #(
  parameter int NUM_HOSTS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,   // host_present_mask
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [2:0] action, [5:3] host_id, [7:6] zero
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata      // [1:0] status, [2] grant_valid,
                                    // [5:3] granted_host, [6] has_work, [7] zero
);

  localparam int CW = $clog2(NUM_HOSTS + 1);

  // control state
  logic [HOST_IDS-1:0] mask_r, mask_nxt;
  logic [HOST_IDS-1:0] active_r, active_nxt;
  logic [HOST_IDS-1:0] xoff_r, xoff_nxt;
  logic [HOST_IDS-1:0] pend_r, pend_nxt;     // hosts still to drop from list
  logic [CW-1:0]       count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;

  // result payload
  status_t             st_r, st_nxt;
  logic                grant_r, grant_nxt;
  logic [HOST_W-1:0]   ghost_r, ghost_nxt;
  logic                work_r, work_nxt;

  logic [HOST_IDS-1:0] lim;                  // ids below NUM_HOSTS
  logic [HOST_IDS-1:0] known;
  logic [HOST_IDS-1:0] gone;
  logic [HOST_IDS-1:0] pend_onehot;
  logic [HOST_W-1:0]   pend_host;
  logic                accept;
  act_t                act;
  logic [HOST_W-1:0]   hid;
  logic                was_elig, now_elig;
  list_ctl_t           ctl;

  logic [HOST_W-1:0]   entry [NUM_HOSTS];
  logic [NUM_HOSTS-1:0] match_c;

  assign act    = act_t'(in_tdata[ACTION_W-1:0]);
  assign hid    = in_tdata[ACTION_W +: HOST_W];
  assign accept = in_tvalid & in_tready;

  assign in_tready  = (pend_r == '0) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, work_r, ghost_r, grant_r, st_r};

  always_comb begin
    for (int h = 0; h < HOST_IDS; h++) begin
      lim[h] = (h < NUM_HOSTS);
    end
  end
  assign known = mask_r & lim;

  // lowest pending host, dropped first
  always_comb begin
    pend_onehot = '0;
    pend_host   = '0;
    for (int h = HOST_IDS - 1; h >= 0; h--) begin
      if (pend_r[h]) begin
        pend_onehot = '0;
        pend_onehot[h] = 1'b1;
        pend_host   = HOST_W'(h);
      end
    end
  end

  // slot chain
  for (genvar i = 0; i < NUM_HOSTS; i++) begin : g_slot
    logic [HOST_W-1:0] right_s;
    logic              match_s;
    if (i == NUM_HOSTS - 1) begin : g_last
      assign right_s = entry[i];
    end else begin : g_mid
      assign right_s = entry[i+1];
    end
    if (i == 0) begin : g_first
      assign match_s = 1'b0;
    end else begin : g_rest
      assign match_s = match_c[i-1];
    end
    xxrr_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .head      (entry[0]),
      .right     (right_s),
      .match_in  (match_s),
      .entry     (entry[i]),
      .match_out (match_c[i])
    );
  end

  always_comb begin
    active_nxt = active_r;
    xoff_nxt   = xoff_r;
    mask_nxt   = mask_r;
    ctl.op     = LOP_NONE;
    ctl.host   = hid;
    st_nxt     = st_r;
    grant_nxt  = grant_r;
    ghost_nxt  = ghost_r;
    was_elig   = active_r[hid] & ~xoff_r[hid];
    now_elig   = was_elig;
    gone       = '0;

    if (pend_r != '0) begin
      ctl.op   = LOP_REMOVE;
      ctl.host = pend_host;
    end else if (accept) begin
      st_nxt    = ST_OK;
      grant_nxt = 1'b0;
      ghost_nxt = '0;
      case (act)
        ACT_SELECT: begin
          if (count_r == '0) begin
            st_nxt = ST_EMPTY;
          end else begin
            ctl.op    = LOP_SELECT;
            grant_nxt = 1'b1;
            ghost_nxt = entry[0];
          end
        end
        ACT_ACTIVE, ACT_INACTIVE, ACT_XOFF, ACT_XON: begin
          if (!known[hid]) begin
            st_nxt = ST_UNKNOWN;
          end else begin
            case (act)
              ACT_ACTIVE:   active_nxt[hid] = 1'b1;
              ACT_INACTIVE: active_nxt[hid] = 1'b0;
              ACT_XOFF:     xoff_nxt[hid]   = 1'b1;
              default:      xoff_nxt[hid]   = 1'b0;
            endcase
            now_elig = active_nxt[hid] & ~xoff_nxt[hid];
            if (was_elig && !now_elig) begin
              ctl.op = LOP_REMOVE;
            end else if (!was_elig && now_elig && (count_r < NUM_HOSTS)) begin
              ctl.op = LOP_APPEND;
            end
          end
        end
        default: ;  // undefined action: no change
      endcase
    end

    case (ctl.op)
      LOP_REMOVE: count_nxt = count_r - CW'(1);
      LOP_APPEND: count_nxt = count_r + CW'(1);
      default:    count_nxt = count_r;
    endcase

    if (accept) begin
      work_nxt = (count_nxt != '0);
    end else begin
      work_nxt = work_r;
    end

    // mask write: dropped hosts lose their flags, eligible ones queue for removal
    if (cfg_wr_en) begin
      mask_nxt = cfg_wr_data;
      gone     = ~(cfg_wr_data & lim);
    end
    pend_nxt   = (pend_r & ~pend_onehot) | (active_nxt & ~xoff_nxt & gone);
    active_nxt = active_nxt & ~gone;
    xoff_nxt   = xoff_nxt & ~gone;

    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      active_r    <= '0;
      xoff_r      <= '0;
      pend_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      active_r    <= active_nxt;
      xoff_r      <= xoff_nxt;
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r    <= st_nxt;
    grant_r <= grant_nxt;
    ghost_r <= ghost_nxt;
    work_r  <= work_nxt;
  end

  // list length tracks the eligible hosts once compaction is done
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == '0) |-> ($countones(active_r & ~xoff_r) == count_r))
    else $error("list length differs from eligible host count");

  // absent hosts hold no flags
  a_flags_known: assert property (@(posedge clk) disable iff (!rst_n)
    ((active_r | xoff_r) & ~known) == '0)
    else $error("flag set on an absent host");

  // a removal always finds its host in the list
  a_remove_found: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == LOP_REMOVE) |-> match_c[NUM_HOSTS-1])
    else $error("removed host not in list");

  // a grant comes with ok status and a non-empty list
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && grant_r) |-> ((st_r == ST_OK) && work_r))
    else $error("grant with bad status or empty list");

endmodule

[hdl/xxrr_cell.sv]
// One slot of the eligible-host list; slots form a shift chain.
// Depends on xxrr_pkg.
module xxrr_cell import xxrr_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 4
) (
  input  logic              clk,
  input  list_ctl_t         ctl,
  input  logic [CW-1:0]     count,
  input  logic [HOST_W-1:0] head,      // slot 0 entry
  input  logic [HOST_W-1:0] right,     // next slot towards the tail
  input  logic              match_in,  // host found in an earlier slot
  output logic [HOST_W-1:0] entry,
  output logic              match_out
);

  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

  logic [HOST_W-1:0] entry_r, entry_nxt;

  assign entry     = entry_r;
  assign match_out = match_in | ((IDX_C < count) && (entry_r == ctl.host));

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      LOP_SELECT: begin
        if (IDX_P1 == count) begin
          entry_nxt = head;       // old head goes to the tail
        end else if (IDX_P1 < count) begin
          entry_nxt = right;
        end
      end
      LOP_REMOVE: begin
        if (match_out) begin
          entry_nxt = right;      // close the gap
        end
      end
      LOP_APPEND: begin
        if (IDX_C == count) begin
          entry_nxt = ctl.host;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
